@@ rtl/u16u8_pkg.sv @@
// Shared constants, the job type and helper functions for the UTF-16 to UTF-8 transcoder.
// Holds the job record passed from the front end to the back end.
// No dependencies.
package u16u8_pkg;

	localparam logic [15:0] SURR_HI_BASE = 16'hD800;
	localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
	localparam logic [15:0] SURR_END     = 16'hE000;
	localparam logic [20:0] SUPP_BASE    = 21'h10000;

	typedef struct packed {
		logic [20:0] cp0;
		logic [2:0]  len0;
		logic [15:0] cp1;
		logic [1:0]  len1;
		logic        last;
	} job_t;

	function automatic logic [2:0] cp_len(input logic [20:0] cp);
		logic [2:0] n;
		if (cp < 21'h80) begin
			n = 3'd1;
		end else if (cp < 21'h800) begin
			n = 3'd2;
		end else if (cp < SUPP_BASE) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
			input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (len)
			3'd1: b = {1'b0, cp[6:0]};
			3'd2: begin
				case (idx)
					2'd0:    b = {3'b110, cp[10:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			3'd3: begin
				case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			3'd4: begin
				case (idx)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/u16u8_front.sv @@
// Front end: accepts code units, tracks surrogate and NUL state and builds jobs.
// Depends on u16u8_pkg.
module u16u8_front
	import u16u8_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	output logic        push,
	output job_t        job
);

	logic [9:0] held_bits_q;
	logic       held_q;
	logic       stopped_q;

	logic       is_low;
	logic       is_high;
	logic       pair_done;
	logic       hold_now;
	logic       stop_now;
	logic [9:0] held_bits_d;
	logic       held_d;
	logic       stopped_d;

	assign is_low  = (code_unit >= SURR_LO_BASE) && (code_unit < SURR_END);
	assign is_high = (code_unit >= SURR_HI_BASE) && (code_unit < SURR_LO_BASE);

	always_comb begin
		job         = '0;
		job.last    = last_unit;
		pair_done   = 1'b0;
		hold_now    = 1'b0;
		stop_now    = 1'b0;
		if (!stopped_q) begin
			if (held_q) begin
				if (is_low) begin
					job.cp0   = SUPP_BASE + 21'({held_bits_q, code_unit[9:0]});
					job.len0  = 3'd4;
					pair_done = 1'b1;
				end else begin
					job.cp0  = 21'(SURR_HI_BASE | {6'd0, held_bits_q});
					job.len0 = 3'd3;
				end
			end
			if (!pair_done) begin
				if (code_unit == 16'd0) begin
					stop_now = 1'b1;
				end else if (is_high && !last_unit) begin
					hold_now = 1'b1;
				end else begin
					job.cp1  = code_unit;
					job.len1 = 2'(cp_len(21'(code_unit)));
				end
			end
		end
	end

	assign push = accept && ((job.len0 != 3'd0) || (job.len1 != 2'd0) || last_unit);

	always_comb begin
		held_bits_d = held_bits_q;
		held_d      = held_q;
		stopped_d   = stopped_q;
		if (!stopped_q && held_q) begin
			held_d      = 1'b0;
			held_bits_d = '0;
		end
		if (hold_now) begin
			held_d      = 1'b1;
			held_bits_d = code_unit[9:0];
		end
		if (stop_now) begin
			stopped_d = 1'b1;
		end
		if (last_unit) begin
			held_d      = 1'b0;
			held_bits_d = '0;
			stopped_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bits_q <= '0;
			held_q      <= 1'b0;
			stopped_q   <= 1'b0;
		end else if (accept) begin
			held_bits_q <= held_bits_d;
			held_q      <= held_d;
			stopped_q   <= stopped_d;
		end
	end

endmodule

@@ rtl/u16u8_fifo.sv @@
// Short job queue between the front end and the back end.
// Depends on u16u8_pkg.
module u16u8_fifo
	import u16u8_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	input  logic pop,
	output job_t rd_job,
	output logic full,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/u16u8_back.sv @@
// Back end: walks the bytes of each job and drives the registered result port.
// Depends on u16u8_pkg.
module u16u8_back
	import u16u8_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       job,
	input  logic       job_ready,
	output logic       pop,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] byte_value,
	output logic       byte_valid,
	output logic       last_of_run,
	output logic       end_of_string
);

	logic [2:0] pos_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       byte_valid_q;
	logic       last_run_q;
	logic       eos_q;

	logic       load;
	logic       advance;
	logic [2:0] total;
	logic       no_bytes;
	logic       final_byte;
	logic       in_first;
	logic [2:0] rel_pos;
	logic [7:0] next_byte;

	assign load     = !out_valid_q || !result_stall;
	assign advance  = load && job_ready;
	assign total    = job.len0 + 3'(job.len1);
	assign no_bytes = (total == 3'd0);
	assign final_byte = no_bytes || (pos_q == total - 3'd1);
	assign in_first = (pos_q < job.len0);
	assign rel_pos  = pos_q - job.len0;

	always_comb begin
		if (in_first) begin
			next_byte = utf8_byte(job.cp0, job.len0, pos_q[1:0]);
		end else begin
			next_byte = utf8_byte(21'(job.cp1), 3'(job.len1), rel_pos[1:0]);
		end
	end

	assign pop = advance && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= job_ready;
			end
			if (advance) begin
				pos_q <= final_byte ? 3'd0 : pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q       <= no_bytes ? 8'h00 : next_byte;
			byte_valid_q <= !no_bytes;
			last_run_q   <= final_byte;
			eos_q        <= final_byte && job.last;
		end
	end

	assign result_valid  = out_valid_q;
	assign byte_value    = byte_q;
	assign byte_valid    = byte_valid_q;
	assign last_of_run   = last_run_q;
	assign end_of_string = eos_q;

endmodule

@@ rtl/utf16_to_utf8_transcoder.sv @@
// UTF-16 to UTF-8 transcoder top level: front end, job queue and byte back end.
// Path: the first byte of a unit is written into the queue and then into the output register
// on its way to the result port.
// Throughput: one unit per cycle in while the queue has room, one result byte per cycle out
// while result_stall is low; a unit yields zero to six bytes (an empty end marker still takes
// one result slot), sent one at a time by the byte-wide back end.
// Reset: arst_n clears surrogate state, queue pointers and the output valid at once.
module utf16_to_utf8_transcoder
	import u16u8_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        unit_valid,
	output logic        unit_stall,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  byte_value,
	output logic        byte_valid,
	output logic        last_of_run,
	output logic        end_of_string
);

	logic accept;
	logic push;
	logic pop;
	logic full;
	logic empty;
	job_t wr_job;
	job_t rd_job;

	assign unit_stall = full;
	assign accept     = unit_valid && !full;

	u16u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.code_unit (code_unit),
		.last_unit (last_unit),
		.push      (push),
		.job       (wr_job)
	);

	u16u8_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.full   (full),
		.empty  (empty)
	);

	u16u8_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (rd_job),
		.job_ready     (!empty),
		.pop           (pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.byte_value    (byte_value),
		.byte_valid    (byte_valid),
		.last_of_run   (last_of_run),
		.end_of_string (end_of_string)
	);

endmodule

@@ rtl/u16u8_checker.sv @@
// Port-level checker for the transcoder and the bind that attaches it.
// Depends only on the top-level ports.
module u16u8_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_stall,
	input logic [7:0] byte_value,
	input logic       byte_valid,
	input logic       last_of_run,
	input logic       end_of_string
);

	// A stalled result transaction stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result_valid dropped while stalled");

	// The end of a string always closes the run of its unit.
	a_eos_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && end_of_string |-> last_of_run)
		else $error("end_of_string without last_of_run");

	// An empty marker only closes a string and carries a zero byte.
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !byte_valid |-> end_of_string && (byte_value == 8'h00))
		else $error("malformed empty end marker");

	// A multi-byte lead byte is always followed by continuation bytes of the same unit.
	a_lead_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && byte_valid && (byte_value[7:6] == 2'b11) |-> !last_of_run)
		else $error("run ends on a lead byte");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_chk (.*);
